/* hdl/ssimd_pkg.sv */
// Shared types, widths and codes for the SSIM 3x3 dissimilarity block.
// Used by the controller, the datapath and the top level; depends on nothing.
package ssimd_pkg;

    localparam int PIX_W     = 8;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 13;
    localparam int ROW_W     = HGT_W + 1;
    localparam int CONST_W   = 24;
    localparam int SUM_W     = PIX_W + 4;
    localparam int SQ_W      = 2 * PIX_W + 4;
    localparam int PSUM_W    = 2 * SUM_W;
    localparam int HALF_W    = 17;
    localparam int OPND_W    = 2 * HALF_W;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int NUM_W     = PROD_W + 18;
    localparam int RES_W     = 16;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C1_CONST     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C2_CONST     = 2'd3;

    // Window columns (oldest to newest) and rows (top to bottom).
    localparam logic [1:0] WIN_OLD = 2'd0;
    localparam logic [1:0] WIN_MID = 2'd1;
    localparam logic [1:0] WIN_NEW = 2'd2;
    localparam logic [1:0] ROW_TOP = 2'd0;
    localparam logic [1:0] ROW_MID = 2'd1;
    localparam logic [1:0] ROW_BOT = 2'd2;

    localparam logic [STEP_W-1:0] ACC_LAST  = 4'd8;
    localparam logic [STEP_W-1:0] MATH_LAST = 4'd13;
    localparam logic [STEP_W-1:0] DIV_LAST  = 4'd15;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] x;
    } pair_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SHIFT, S_ACC, S_MATH, S_DPREP, S_DIV, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_SXSY, OP_SXSX, OP_SYSY, OP_FORM,
        OP_N00, OP_N01, OP_N10, OP_N11,
        OP_D00, OP_D01, OP_D10, OP_D11
    } op_t;

    typedef struct packed {
        logic             latch;
        logic             zero_pix;
        logic [COL_W-1:0] addr;
        logic             mem_rd;
        logic             shift_en;
        logic             acc_en;
        logic             acc_first;
        logic [1:0]       acc_src;
        logic [1:0]       acc_row;
        op_t              op;
        logic             div_init;
        logic             div_step;
        logic             load_out;
        logic             row_end;
        logic             frame_end;
    } cmd_t;

    typedef struct packed {
        logic fixed;
    } status_t;

    // Arithmetic sequence: three small products, factor forming, then the
    // two wide products as four partial products each.
    function automatic op_t math_op(input logic [STEP_W-1:0] step);
        op_t op;
        begin
            case (step)
                4'd0:    op = OP_SXSY;
                4'd1:    op = OP_SXSX;
                4'd2:    op = OP_SYSY;
                4'd4:    op = OP_FORM;
                4'd5:    op = OP_N00;
                4'd6:    op = OP_N01;
                4'd7:    op = OP_N10;
                4'd8:    op = OP_N11;
                4'd9:    op = OP_D00;
                4'd10:   op = OP_D01;
                4'd11:   op = OP_D10;
                4'd12:   op = OP_D11;
                default: op = OP_NONE;
            endcase
            return op;
        end
    endfunction

endpackage

/* hdl/ssim_box3_dissimilarity.sv */
// Top level of the SSIM 3x3 box-window dissimilarity block.
// Holds the configuration registers; instantiates ssimd_ctrl and ssimd_dp.
//
// Usage: pixel pairs of two same-size images enter in raster order on the
// slave stream, one beat per pixel; s_axis_tuser set marks a drain beat with
// no pixels. After the last pixel of a frame, width+1 drain beats flush the
// last row. Each result is (1-SSIM)/2 of a pixel's reflected 3x3 window in
// Q1.15, and belongs to the pixel one row plus one pixel before the beat
// that produced it. m_axis_tlast marks the last result of a frame.
// Throughput: one item at a time. A beat that causes no result makes
// one line-store read and one write-back. A beat with a result goes
// through the window sum, the 14-step product sequence on the single
// 17x17 multiplier and the 16-step restoring
// divider. When the ratio settles early (zero denominator or clamped result)
// the divider is skipped. The result register lets the next beat be taken
// while a result waits; a stalled master side holds the block only when a
// second result is ready. Reset clears counters, window and handshakes and
// loads the default geometry and constants; line stores need no clearing.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module ssim_box3_dissimilarity (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] pixel_x, [15:8] pixel_y
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] dissimilarity
    output logic [1:0]  m_axis_tuser,   // [0] denom_zero, [1] row_end
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import ssimd_pkg::*;

    logic [WID_W-1:0]   width_reg;
    logic [HGT_W-1:0]   height_reg;
    logic [CONST_W-1:0] c1_reg, c2_reg;
    cmd_t               cmd;
    status_t            sts;
    logic               row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(640);
            height_reg <= HGT_W'(192);
            c1_reg     <= CONST_W'(1665);
            c2_reg     <= CONST_W'(134835);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                REG_C1_CONST:     c1_reg     <= cfg_data;
                REG_C2_CONST:     c2_reg     <= cfg_data;
                default:          c2_reg     <= c2_reg;
            endcase
        end
    end

    ssimd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .func         (s_axis_tuser[0]),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .cmd          (cmd),
        .sts          (sts)
    );

    ssimd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .pixel_x       (s_axis_tdata[7:0]),
        .pixel_y       (s_axis_tdata[15:8]),
        .c1_const      (c1_reg),
        .c2_const      (c2_reg),
        .dissimilarity (m_axis_tdata),
        .denom_zero    (m_axis_tuser[0]),
        .row_end       (row_end),
        .frame_end     (m_axis_tlast)
    );

    assign m_axis_tuser[1] = row_end;

endmodule

/* hdl/ssimd_ctrl.sv */
// Controller: frame position counters, edge decisions and the item sequencer.
// Depends on ssimd_pkg; drives the datapath through cmd_t.
module ssimd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   func,
    input  logic [ssimd_pkg::WID_W-1:0] image_width,
    input  logic [ssimd_pkg::HGT_W-1:0] image_height,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ssimd_pkg::cmd_t        cmd,
    input  ssimd_pkg::status_t     sts
);
    import ssimd_pkg::*;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               out_valid_reg, out_valid_next;
    logic               first_reg, emit_reg, fend_reg, rend_reg, top_reg, bot_reg;
    logic [1:0]         left_reg, mid_reg, right_reg;

    logic [WID_W-1:0]   w_eff;
    logic [HGT_W-1:0]   h_eff;
    logic               wrap, c_zero, drain, ignore, emit, fend, go;
    logic [COL_W-1:0]   c_eff;
    logic [ROW_W-1:0]   r_eff, h_ext;
    logic [WID_W-1:0]   c_inc;
    logic [1:0]         colpos, rowpos;

    always_comb
    begin
        if (image_width < WID_W'(2))
            w_eff = WID_W'(2);
        else if (image_width > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = image_width;
        h_eff  = (image_height < HGT_W'(2)) ? HGT_W'(2) : image_height;
        h_ext  = ROW_W'(h_eff);
        wrap   = WID_W'(col_reg) >= w_eff;
        c_eff  = wrap ? '0 : col_reg;
        r_eff  = wrap ? row_reg + ROW_W'(1) : row_reg;
        c_zero = (c_eff == '0);
        drain  = r_eff >= h_ext;
        ignore = func && !drain;
        emit   = (r_eff >= ROW_W'(2)) || ((r_eff == ROW_W'(1)) && !c_zero);
        fend   = c_zero && emit && (r_eff >= h_ext + ROW_W'(1));
        c_inc  = WID_W'(c_eff) + WID_W'(1);
        go     = (state_reg == S_IDLE) && in_valid;
    end

    // Position counters move at the accept edge.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (go)
        begin
            if (ignore)
            begin
                col_next = c_eff;
                row_next = r_eff;
            end
            else if (fend)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = r_eff + ROW_W'(1);
            end
            else
            begin
                col_next = c_inc[COL_W-1:0];
                row_next = r_eff;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
                if (go && !ignore)
                begin
                    state_next = (c_zero && emit) ? S_ACC : S_READ;
                    step_next  = '0;
                end
            S_READ:
                state_next = S_SHIFT;
            S_SHIFT:
            begin
                step_next = '0;
                if (first_reg)
                    state_next = S_MATH;
                else if (emit_reg)
                    state_next = S_ACC;
                else
                    state_next = S_IDLE;
            end
            S_ACC:
                if (step_reg == ACC_LAST)
                begin
                    step_next  = '0;
                    state_next = (first_reg && !fend_reg) ? S_READ : S_MATH;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            S_MATH:
                if (step_reg == MATH_LAST)
                    state_next = S_DPREP;
                else
                    step_next = step_reg + STEP_W'(1);
            S_DPREP:
            begin
                step_next  = '0;
                state_next = sts.fixed ? S_DONE : S_DIV;
            end
            S_DIV:
                if (step_reg == DIV_LAST)
                    state_next = S_DONE;
                else
                    step_next = step_reg + STEP_W'(1);
            S_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (step_reg >= STEP_W'(6))
            colpos = 2'd2;
        else if (step_reg >= STEP_W'(3))
            colpos = 2'd1;
        else
            colpos = 2'd0;
        rowpos = 2'(step_reg - STEP_W'(3) * STEP_W'(colpos));
    end

    always_comb
    begin
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.addr      = c_eff;
        cmd.row_end   = rend_reg;
        cmd.frame_end = fend_reg;
        cmd.acc_first = (step_reg == '0);
        unique case (colpos)
            2'd0:    cmd.acc_src = left_reg;
            2'd1:    cmd.acc_src = mid_reg;
            default: cmd.acc_src = right_reg;
        endcase
        unique case (rowpos)
            2'd0:    cmd.acc_row = top_reg ? ROW_BOT : ROW_TOP;
            2'd1:    cmd.acc_row = ROW_MID;
            default: cmd.acc_row = bot_reg ? ROW_TOP : ROW_BOT;
        endcase
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch    = go && !ignore;
                cmd.zero_pix = drain;
            end
            S_READ:  cmd.mem_rd   = 1'b1;
            S_SHIFT: cmd.shift_en = 1'b1;
            S_ACC:   cmd.acc_en   = 1'b1;
            S_MATH:  cmd.op       = math_op(step_reg);
            S_DPREP: cmd.div_init = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_DONE:  cmd.load_out = !out_valid_reg || out_ready;
            default: cmd.latch    = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            fend_reg      <= 1'b0;
            rend_reg      <= 1'b0;
            top_reg       <= 1'b0;
            bot_reg       <= 1'b0;
            left_reg      <= WIN_OLD;
            mid_reg       <= WIN_MID;
            right_reg     <= WIN_NEW;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cmd.latch)
            begin
                first_reg <= c_zero && emit;
                emit_reg  <= emit;
                fend_reg  <= fend;
                rend_reg  <= c_zero;
                top_reg   <= c_zero ? (r_eff == ROW_W'(2)) : (r_eff == ROW_W'(1));
                bot_reg   <= c_zero ? (r_eff >= h_ext + ROW_W'(1)) : (r_eff >= h_ext);
                // At a row start the window holds the last two pixels of the
                // row above, and the right edge reflects onto the left column.
                if (c_zero)
                begin
                    left_reg  <= WIN_MID;
                    mid_reg   <= WIN_NEW;
                    right_reg <= WIN_MID;
                end
                else
                begin
                    left_reg  <= (c_eff == COL_W'(1)) ? WIN_NEW : WIN_OLD;
                    mid_reg   <= WIN_MID;
                    right_reg <= WIN_NEW;
                end
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !ignore && fend) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared at frame end");
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DPREP && !sts.fixed) |-> ##17 (state_reg == S_DONE))
        else $error("division did not take sixteen steps");

endmodule

/* hdl/ssimd_dp.sv */
// Datapath: line stores, 3x3 window, window sums, shared multiplier and the
// restoring divider. Depends on ssimd_pkg; sequenced by ssimd_ctrl.
module ssimd_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ssimd_pkg::cmd_t          cmd,
    output ssimd_pkg::status_t       sts,
    input  logic [ssimd_pkg::PIX_W-1:0]   pixel_x,
    input  logic [ssimd_pkg::PIX_W-1:0]   pixel_y,
    input  logic [ssimd_pkg::CONST_W-1:0] c1_const,
    input  logic [ssimd_pkg::CONST_W-1:0] c2_const,
    output logic [ssimd_pkg::RES_W-1:0]   dissimilarity,
    output logic                     denom_zero,
    output logic                     row_end,
    output logic                     frame_end
);
    import ssimd_pkg::*;

    pair_t            upper_mem [MAX_WIDTH];
    pair_t            middle_mem [MAX_WIDTH];
    pair_t            u_q_reg, m_q_reg, v_reg;
    logic [COL_W-1:0] addr_reg;
    pair_t            win_reg [3][3];

    logic [SUM_W-1:0]  sx_reg, sy_reg;
    logic [SQ_W-1:0]   sxx_reg, syy_reg, sxy_reg;
    logic [PSUM_W-1:0] p_sxsy_reg, p_sx2_reg, p_sy2_reg;
    logic [OPND_W-1:0] f1n_reg, mag_reg, f1d_reg, f2d_reg;
    logic              neg_reg;
    logic [OPND_W-1:0] prod_reg;
    op_t               op_d_reg;
    logic [PROD_W-1:0] n_reg, d_reg;
    logic [NUM_W-1:0]  num_reg, dsh_reg;
    logic [RES_W-1:0]  q16_reg, fixed_val_reg;
    logic              fixed_reg, dz_reg;
    logic [RES_W-1:0]  dis_reg;
    logic              dzo_reg, rend_reg, fend_reg;

    pair_t             sel;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [30:0]       k1, k2;
    logic [SQ_W+3:0]   nine_sxy, nine_sxx, nine_syy;
    logic signed [25:0] cov_t;
    logic signed [35:0] f2n;
    logic [24:0]       var_t;
    logic              dz, ge;
    logic [PROD_W:0]   q_t;
    logic              take;

    // Line stores: each read is written back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            u_q_reg <= upper_mem[addr_reg];
            m_q_reg <= middle_mem[addr_reg];
        end
        if (cmd.shift_en)
        begin
            upper_mem[addr_reg]  <= m_q_reg;
            middle_mem[addr_reg] <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            addr_reg <= cmd.addr;
            v_reg.x  <= cmd.zero_pix ? '0 : pixel_x;
            v_reg.y  <= cmd.zero_pix ? '0 : pixel_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else if (cmd.shift_en)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= u_q_reg;
            win_reg[2][1] <= m_q_reg;
            win_reg[2][2] <= v_reg;
        end
    end

    assign sel = win_reg[cmd.acc_src][cmd.acc_row];

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            sx_reg  <= (cmd.acc_first ? '0 : sx_reg) + SUM_W'(sel.x);
            sy_reg  <= (cmd.acc_first ? '0 : sy_reg) + SUM_W'(sel.y);
            sxx_reg <= (cmd.acc_first ? '0 : sxx_reg) + SQ_W'(sel.x * sel.x);
            syy_reg <= (cmd.acc_first ? '0 : syy_reg) + SQ_W'(sel.y * sel.y);
            sxy_reg <= (cmd.acc_first ? '0 : sxy_reg) + SQ_W'(sel.x * sel.y);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SXSY: begin mul_a = HALF_W'(sx_reg); mul_b = HALF_W'(sy_reg); end
            OP_SXSX: begin mul_a = HALF_W'(sx_reg); mul_b = HALF_W'(sx_reg); end
            OP_SYSY: begin mul_a = HALF_W'(sy_reg); mul_b = HALF_W'(sy_reg); end
            OP_N00:  begin mul_a = f1n_reg[HALF_W-1:0]; mul_b = mag_reg[HALF_W-1:0]; end
            OP_N01:  begin mul_a = f1n_reg[HALF_W-1:0]; mul_b = mag_reg[OPND_W-1:HALF_W]; end
            OP_N10:  begin mul_a = f1n_reg[OPND_W-1:HALF_W]; mul_b = mag_reg[HALF_W-1:0]; end
            OP_N11:  begin mul_a = f1n_reg[OPND_W-1:HALF_W]; mul_b = mag_reg[OPND_W-1:HALF_W]; end
            OP_D00:  begin mul_a = f1d_reg[HALF_W-1:0]; mul_b = f2d_reg[HALF_W-1:0]; end
            OP_D01:  begin mul_a = f1d_reg[HALF_W-1:0]; mul_b = f2d_reg[OPND_W-1:HALF_W]; end
            OP_D10:  begin mul_a = f1d_reg[OPND_W-1:HALF_W]; mul_b = f2d_reg[HALF_W-1:0]; end
            OP_D11:  begin mul_a = f1d_reg[OPND_W-1:HALF_W]; mul_b = f2d_reg[OPND_W-1:HALF_W]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Factors of the SSIM ratio, all scaled by 81 * 256 so that they stay
    // integral.
    always_comb
    begin
        k1       = (31'(c1_const) << 6) + (31'(c1_const) << 4) + 31'(c1_const);
        k2       = (31'(c2_const) << 6) + (31'(c2_const) << 4) + 31'(c2_const);
        nine_sxy = ((SQ_W+4)'(sxy_reg) << 3) + (SQ_W+4)'(sxy_reg);
        nine_sxx = ((SQ_W+4)'(sxx_reg) << 3) + (SQ_W+4)'(sxx_reg);
        nine_syy = ((SQ_W+4)'(syy_reg) << 3) + (SQ_W+4)'(syy_reg);
        cov_t    = $signed({2'b00, nine_sxy}) - $signed({2'b00, p_sxsy_reg});
        f2n      = $signed({cov_t[25], cov_t, 9'b0}) + $signed({5'b0, k2});
        var_t    = 25'(nine_sxx) + 25'(nine_syy) - 25'(p_sx2_reg) - 25'(p_sy2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_d_reg <= OP_NONE;
        else
            op_d_reg <= cmd.op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.op == OP_FORM)
        begin
            f1n_reg <= OPND_W'({p_sxsy_reg, 9'b0}) + OPND_W'(k1);
            f1d_reg <= OPND_W'({25'(p_sx2_reg) + 25'(p_sy2_reg), 8'b0}) + OPND_W'(k1);
            f2d_reg <= OPND_W'({var_t, 8'b0}) + OPND_W'(k2);
            neg_reg <= f2n[35];
            mag_reg <= f2n[35] ? OPND_W'(-f2n) : OPND_W'(f2n);
        end
        unique case (op_d_reg)
            OP_SXSY: p_sxsy_reg <= PSUM_W'(prod_reg);
            OP_SXSX: p_sx2_reg  <= PSUM_W'(prod_reg);
            OP_SYSY: p_sy2_reg  <= PSUM_W'(prod_reg);
            OP_N00:  n_reg <= PROD_W'(prod_reg);
            OP_N01,
            OP_N10:  n_reg <= n_reg + (PROD_W'(prod_reg) << HALF_W);
            OP_N11:  n_reg <= n_reg + (PROD_W'(prod_reg) << OPND_W);
            OP_D00:  d_reg <= PROD_W'(prod_reg);
            OP_D01,
            OP_D10:  d_reg <= d_reg + (PROD_W'(prod_reg) << HALF_W);
            OP_D11:  d_reg <= d_reg + (PROD_W'(prod_reg) << OPND_W);
            default: n_reg <= n_reg;
        endcase
    end

    // Division setup: a zero denominator or N >= D settles the result at once.
    always_comb
    begin
        dz        = (d_reg == '0);
        ge        = (n_reg >= d_reg);
        sts.fixed = dz || ge;
        q_t       = neg_reg ? ({1'b0, d_reg} + {1'b0, n_reg})
                            : ({1'b0, d_reg} - {1'b0, n_reg});
        take      = (num_reg >= dsh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            fixed_reg     <= dz || ge;
            dz_reg        <= dz;
            fixed_val_reg <= (!dz && neg_reg) ? RES_W'(32768) : '0;
            num_reg       <= (NUM_W'(q_t) << 15) + NUM_W'(d_reg);
            dsh_reg       <= NUM_W'(d_reg) << 16;
            q16_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= take ? num_reg - dsh_reg : num_reg;
            dsh_reg <= dsh_reg >> 1;
            q16_reg <= {q16_reg[RES_W-2:0], take};
        end
        if (cmd.load_out)
        begin
            dis_reg  <= fixed_reg ? fixed_val_reg : q16_reg;
            dzo_reg  <= dz_reg;
            rend_reg <= cmd.row_end;
            fend_reg <= cmd.frame_end;
        end
    end

    assign dissimilarity = dis_reg;
    assign denom_zero    = dzo_reg;
    assign row_end       = rend_reg;
    assign frame_end     = fend_reg;

endmodule
